/* rtl/stdd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stdd_pkg: shared types and constants for the slot table unit
// Operation and status codes, default table size and the store request.
// ----------------------------------------------------------------------------
package stdd_pkg;

  // Default number of slots
  localparam int SLOTS_DEF = 16;

  // Widest slot address over the supported table sizes (up to 256 slots)
  localparam int ADDR_MAX_W = 8;

  // Width of one stored value
  localparam int VAL_W = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_DEDUP  = 2'd3
  } op_e_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_OCCUPIED  = 3'd2,
    ST_RANGE     = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_ABSENT    = 3'd5,
    ST_NOT_FOUND = 3'd6
  } status_e_t;

  // Update request from the sequencer to the slot store
  typedef struct packed {
    logic                   wr;    // write value and mark slot valid
    logic                   clr;   // mark slot empty
    logic [ADDR_MAX_W-1:0]  addr;
    logic [VAL_W-1:0]       data;
  } store_req_t;

endpackage

/* rtl/stdd_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stdd_store: slot value memory, valid bits and occupancy count
// One write or clear per cycle, one registered read port.
// ----------------------------------------------------------------------------
module stdd_store #(
  parameter int SLOTS = stdd_pkg::SLOTS_DEF,
  localparam int IDX_W = $clog2(SLOTS),
  localparam int CNT_W = $clog2(SLOTS + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  stdd_pkg::store_req_t        req,
  input  logic [IDX_W-1:0]            rd_addr,
  output logic [stdd_pkg::VAL_W-1:0]  rd_data,
  output logic [SLOTS-1:0]            valid,
  output logic [CNT_W-1:0]            count
);
  import stdd_pkg::*;

  logic [VAL_W-1:0] mem [SLOTS];
  logic [IDX_W-1:0] req_idx;

  assign req_idx = req.addr[IDX_W-1:0];

  // Value memory: write on insert, registered read
  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req_idx] <= req.data;
    end
    rd_data <= mem[rd_addr];
  end

  // Track valid bits and count of valid slots
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
    end else if (req.wr) begin
      valid[req_idx] <= 1'b1;
      count          <= count + CNT_W'(1);
    end else if (req.clr) begin
      valid[req_idx] <= 1'b0;
      count          <= count - CNT_W'(1);
    end
  end

endmodule

/* rtl/slot_table_insert_delete_dedup_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_table_insert_delete_dedup_unit: slot table with search and dedup
// Insert, delete, search and duplicate removal over a table of signed
// values, sequenced around one shared 32-bit equality comparator.
//
//   channel  dir  handshake         payload
//   s_*      in   s_tvalid/tready   operation, location, value
//   m_*      out  m_tvalid/tready   status, found_slot, occupied_count
//
// Insert and delete pass through S_DONE and load the result register once it is free.
// Search walks every slot through the memory read port.
// Remove duplicates compares each valid slot i against slots 0..i-1 on the
// same comparator.
// s_tready is high only while idle; a held result does not block the next
// transfer in. Reset clears all valid bits and the count.
// ----------------------------------------------------------------------------
module slot_table_insert_delete_dedup_unit #(
  parameter int SLOTS = stdd_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // operation[1:0], location[9:2], value[41:10], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // status[2:0], found_slot[6:3], occupied_count[11:7], pad
);
  import stdd_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DOUT,
    S_DKEY,
    S_DONE
  } state_t;

  state_t              state;
  op_e_t               op_reg;
  logic [VAL_W-1:0]    key;
  logic [CNT_W-1:0]    lim;
  logic [CNT_W-1:0]    rd_idx;
  logic                rd_live;
  logic [IDX_W-1:0]    rd_tag;
  logic                hit;
  logic [IDX_W-1:0]    hit_idx;
  logic [CNT_W-1:0]    outer;
  status_e_t           res_status;
  logic [3:0]          res_found;
  status_e_t           out_status;
  logic [3:0]          out_found;
  logic [4:0]          out_count;

  // Input fields
  op_e_t               op_in;
  logic [7:0]          loc_in;
  logic [VAL_W-1:0]    val_in;
  logic                accept;
  logic                in_range;
  logic [IDX_W-1:0]    loc_idx;
  logic [IDX_W-1:0]    outer_idx;

  // Store interface
  store_req_t          req;
  logic [IDX_W-1:0]    rd_addr;
  logic [VAL_W-1:0]    rd_data;
  logic [SLOTS-1:0]    valid;
  logic [CNT_W-1:0]    count;

  status_e_t           imm_status;
  logic                do_wr;
  logic                do_clr;
  logic                cmp_eq;
  logic                scan_done;
  logic                dedup_clr;
  logic                out_load;

  assign op_in     = op_e_t'(s_tdata[1:0]);
  assign loc_in    = s_tdata[9:2];
  assign val_in    = s_tdata[41:10];
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign in_range  = ({1'b0, loc_in} < 9'(SLOTS));
  assign loc_idx   = loc_in[IDX_W-1:0];
  assign outer_idx = outer[IDX_W-1:0];

  // Shared comparator and scan termination
  assign cmp_eq    = (rd_data == key);
  assign scan_done = !rd_live && (rd_idx >= lim);
  assign dedup_clr = (state == S_SCAN) && scan_done && (op_reg == OP_DEDUP) && hit;

  // Result register loads when the finished result finds it free
  assign out_load  = (state == S_DONE) && (!m_tvalid || m_tready);

  assign m_tdata = {4'd0, out_count, out_found, out_status};

  // Decode insert and delete checks in the accept cycle
  always_comb begin
    imm_status = ST_OK;
    do_wr      = 1'b0;
    do_clr     = 1'b0;
    case (op_in)
      OP_INSERT: begin
        if (count == CNT_W'(SLOTS)) begin
          imm_status = ST_FULL;
        end else if (!in_range) begin
          imm_status = ST_RANGE;
        end else if (valid[loc_idx]) begin
          imm_status = ST_OCCUPIED;
        end else begin
          do_wr = 1'b1;
        end
      end
      OP_DELETE: begin
        if (count == '0) begin
          imm_status = ST_EMPTY;
        end else if (!in_range) begin
          imm_status = ST_RANGE;
        end else if (!valid[loc_idx]) begin
          imm_status = ST_ABSENT;
        end else begin
          do_clr = 1'b1;
        end
      end
      default: begin
        imm_status = ST_OK;
      end
    endcase
  end

  // Store request and read address
  always_comb begin
    req.wr   = accept && do_wr;
    req.clr  = (accept && do_clr) || dedup_clr;
    req.addr = dedup_clr ? ADDR_MAX_W'(outer_idx) : loc_in;
    req.data = val_in;
    rd_addr  = (state == S_DOUT) ? outer_idx : rd_idx[IDX_W-1:0];
  end

  stdd_store #(
    .SLOTS (SLOTS)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .valid   (valid),
    .count   (count)
  );

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rd_live  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // Load a new result, or drop the held one once it transfers
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_reg  <= op_in;
            rd_idx  <= '0;
            rd_live <= 1'b0;
            hit     <= 1'b0;
            case (op_in)
              OP_SEARCH: begin
                key   <= val_in;
                lim   <= CNT_W'(SLOTS);
                state <= S_SCAN;
              end
              OP_DEDUP: begin
                outer <= '0;
                state <= S_DOUT;
              end
              default: begin
                res_status <= imm_status;
                res_found  <= '0;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          // Issue the next read, compare the one that just returned
          if (rd_idx < lim) begin
            rd_tag  <= rd_idx[IDX_W-1:0];
            rd_idx  <= rd_idx + CNT_W'(1);
            rd_live <= 1'b1;
          end else begin
            rd_live <= 1'b0;
          end
          if (rd_live && valid[rd_tag] && cmp_eq) begin
            hit     <= 1'b1;
            hit_idx <= rd_tag;
          end
          if (scan_done) begin
            if (op_reg == OP_DEDUP) begin
              outer <= outer + CNT_W'(1);
              state <= S_DOUT;
            end else begin
              res_status <= hit ? ST_OK : ST_NOT_FOUND;
              res_found  <= hit ? 4'(hit_idx) : 4'd0;
              state      <= S_DONE;
            end
          end
        end
        S_DOUT: begin
          // Pick the next valid slot to check against the lower ones
          if (outer == CNT_W'(SLOTS)) begin
            res_status <= ST_OK;
            res_found  <= '0;
            state      <= S_DONE;
          end else if (!valid[outer_idx]) begin
            outer <= outer + CNT_W'(1);
          end else begin
            state <= S_DKEY;
          end
        end
        S_DKEY: begin
          // Latch the slot value as the compare key, scan lower slots
          key     <= rd_data;
          lim     <= outer;
          rd_idx  <= '0;
          rd_live <= 1'b0;
          hit     <= 1'b0;
          state   <= S_SCAN;
        end
        S_DONE: begin
          // Hold until the result register is free
          if (out_load) begin
            out_status <= res_status;
            out_found  <= res_found;
            out_count  <= 5'(count);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for slot_table_insert_delete_dedup_unit
// Streams insert, delete, search and dedup requests into the slot table. A
// shadow copy of the table predicts status, found slot and occupancy for
// every accepted request. Results are checked in order. The bench runs
// several phases of sender gaps and receiver stalls, plus one long output
// hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import stdd_pkg::*;

  localparam int N_SLOTS     = SLOTS_DEF;
  localparam int QUIET_LIMIT = 4000;   // cycles with no transfer on either side
  localparam int HOLD_CYCLES = 400;    // long receiver hold-off
  localparam int DRAIN_WAIT  = 200;    // above the worst dedup latency
  localparam int PHASE_ITEMS = 110;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    op_e_t       op;
    logic [7:0]  loc;
    logic [31:0] val;
  } table_req_t;

  typedef struct {
    status_e_t   status;
    logic [3:0]  slot;
    logic [4:0]  count;
  } table_outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // operation[1:0], location[9:2], value[41:10], pad
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // status[2:0], found_slot[6:3], occupied_count[11:7], pad

  table_req_t     req_queue[$];
  table_outcome_t pending_outcomes[$];
  int             queued_count = 0;
  int             accepted_count = 0;
  int             errors = 0;
  int             quiet_cycles = 0;
  idle_mode_t     idle_mode = IDLE_NONE;
  bit             hold_arm = 1'b0;

  // Shadow table
  logic [31:0] tbl_value [N_SLOTS];
  logic        tbl_valid [N_SLOTS];
  int          tbl_count;

  slot_table_insert_delete_dedup_unit #(.SLOTS(N_SLOTS)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  function automatic int idle_pct(idle_mode_t mode, bit sender);
    if (mode == IDLE_BOTH) return 15;
    if (sender && mode == IDLE_SEND) return 74;
    if (!sender && mode == IDLE_RECV) return 74;
    return 0;
  endfunction

  // Apply one request to the shadow table and return the expected result
  task automatic apply_table_op(input table_req_t r, output table_outcome_t o);
    o.status = ST_OK;
    o.slot   = '0;
    case (r.op)
      OP_INSERT: begin
        if (tbl_count >= N_SLOTS) o.status = ST_FULL;
        else if (r.loc >= N_SLOTS) o.status = ST_RANGE;
        else if (tbl_valid[r.loc]) o.status = ST_OCCUPIED;
        else begin
          tbl_value[r.loc] = r.val;
          tbl_valid[r.loc] = 1'b1;
          tbl_count++;
        end
      end
      OP_DELETE: begin
        if (tbl_count == 0) o.status = ST_EMPTY;
        else if (r.loc >= N_SLOTS) o.status = ST_RANGE;
        else if (!tbl_valid[r.loc]) o.status = ST_ABSENT;
        else begin
          tbl_valid[r.loc] = 1'b0;
          tbl_count--;
        end
      end
      OP_SEARCH: begin
        o.status = ST_NOT_FOUND;
        for (int i = 0; i < N_SLOTS; i++) begin
          if (tbl_valid[i] && tbl_value[i] == r.val) begin
            o.status = ST_OK;
            o.slot   = i[3:0];
          end
        end
      end
      default: begin
        // Drop every slot that repeats a kept lower slot
        for (int i = 0; i < N_SLOTS; i++) begin
          if (tbl_valid[i]) begin
            for (int j = 0; j < i; j++) begin
              if (tbl_valid[i] && tbl_valid[j] && tbl_value[j] == tbl_value[i]) begin
                tbl_valid[i] = 1'b0;
                tbl_count--;
              end
            end
          end
        end
      end
    endcase
    o.count = tbl_count[4:0];
  endtask

  task automatic report_field(string name, int expv, int actv);
    $display("%0t ERROR %s mismatch: expected %0d actual %0d", $time, name, expv, actv);
    errors++;
  endtask

  // Predict on each input transfer, check each output transfer
  always @(posedge clk) begin : scoreboard
    table_req_t     r;
    table_outcome_t o;
    if (rst) begin
      for (int i = 0; i < N_SLOTS; i++) begin
        tbl_value[i] = '0;
        tbl_valid[i] = 1'b0;
      end
      tbl_count = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        r.op  = op_e_t'(s_tdata[1:0]);
        r.loc = s_tdata[9:2];
        r.val = s_tdata[41:10];
        apply_table_op(r, o);
        pending_outcomes.push_back(o);
        accepted_count++;
      end
      if (m_tvalid && m_tready) begin
        if (pending_outcomes.size() == 0) begin
          $display("%0t ERROR unexpected result: expected none actual %h", $time, m_tdata);
          errors++;
        end else begin
          o = pending_outcomes.pop_front();
          if (m_tdata[2:0] != o.status) report_field("status", o.status, m_tdata[2:0]);
          if (m_tdata[6:3] != o.slot) report_field("found_slot", o.slot, m_tdata[6:3]);
          if (m_tdata[11:7] != o.count) report_field("occupied_count", o.count, m_tdata[11:7]);
        end
      end
    end
  end

  // Sender: hold each item until it transfers, insert random gaps
  always @(posedge clk) begin : driver
    table_req_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else if (!s_tvalid || s_tready) begin
      if (req_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct(idle_mode, 1'b1)) begin
        nxt = req_queue.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, nxt.val, nxt.loc, nxt.op};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, one long hold-off when armed
  always @(posedge clk) begin : receiver
    int  hold_left;
    bit  hold_done;
    if (rst) begin
      m_tready  <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_arm && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= idle_pct(idle_mode, 1'b0));
    end
  end

  // Count cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t watchdog expired", $time);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic add_req(op_e_t op, int loc, logic [31:0] val);
    table_req_t r;
    r.op  = op;
    r.loc = loc[7:0];
    r.val = val;
    req_queue.push_back(r);
    queued_count++;
  endtask

  // Values mostly from a small pool so that searches hit and dedup has work
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3, 4: return $urandom;
      default: return $urandom_range(0, 5);
    endcase
  endfunction

  function automatic int pick_loc();
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, N_SLOTS - 1);
    return $urandom_range(N_SLOTS, 255);
  endfunction

  // Fill every slot in random order, then hit the full table
  task automatic add_fill_burst(int tail_loc);
    int order[N_SLOTS];
    int j, t;
    for (int i = 0; i < N_SLOTS; i++) order[i] = i;
    for (int i = N_SLOTS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < N_SLOTS; i++) add_req(OP_INSERT, order[i], pick_value());
    add_req(OP_INSERT, tail_loc, pick_value());
    add_req(OP_SEARCH, $urandom_range(0, 255), pick_value());
    add_req(OP_DEDUP, $urandom_range(0, 255), $urandom);
  endtask

  task automatic add_random_phase(int n);
    int start, r;
    start = queued_count;
    add_fill_burst(255);
    while (queued_count - start < n) begin
      if ($urandom_range(0, 99) < 8) begin
        add_fill_burst(pick_loc());
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40) add_req(OP_INSERT, pick_loc(), pick_value());
        else if (r < 65) add_req(OP_DELETE, pick_loc(), $urandom);
        else if (r < 90) add_req(OP_SEARCH, $urandom_range(0, 255), pick_value());
        else add_req(OP_DEDUP, $urandom_range(0, 255), $urandom);
      end
    end
  endtask

  // Pause the sender until every expected result is back
  task automatic wait_drained();
    while (!(accepted_count == queued_count && pending_outcomes.size() == 0))
      @(posedge clk);
  endtask

  initial begin : main
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: error codes, value extremes, highest-index search, dedup
    add_req(OP_DELETE, 255, 32'h0);          // empty table wins over range
    add_req(OP_SEARCH, 0, 32'h0);            // empty slots never match
    add_req(OP_DEDUP, 0, 32'h0);
    add_req(OP_INSERT, 0, 32'h8000_0000);
    add_req(OP_INSERT, 15, 32'h7FFF_FFFF);
    add_req(OP_INSERT, 16, 32'h1);
    add_req(OP_INSERT, 255, 32'h0);
    add_req(OP_INSERT, 0, 32'h1);            // occupied
    add_req(OP_DELETE, 3, 32'hFFFF_FFFF);    // not present
    add_req(OP_DELETE, 200, 32'h0);
    add_req(OP_SEARCH, 170, 32'h7FFF_FFFF);
    add_req(OP_SEARCH, 85, 32'h5);
    add_req(OP_INSERT, 7, 32'h8000_0000);
    add_req(OP_INSERT, 9, 32'h8000_0000);
    add_req(OP_SEARCH, 0, 32'h8000_0000);    // highest matching slot
    add_req(OP_DEDUP, 255, 32'hFFFF_FFFF);
    add_req(OP_SEARCH, 0, 32'h8000_0000);    // only slot 0 still matches
    add_req(OP_DELETE, 0, 32'h0);
    add_req(OP_DELETE, 15, 32'h0);
    add_req(OP_INSERT, 3, 32'hFFFF_FFFF);
    add_req(OP_INSERT, 4, 32'hFFFF_FFFF);
    add_req(OP_INSERT, 5, 32'hFFFF_FFFF);
    add_req(OP_DEDUP, 0, 32'h0);
    add_req(OP_SEARCH, 0, 32'hFFFF_FFFF);
    wait_drained();

    // Random phases across the idling modes
    idle_mode = IDLE_NONE;
    add_random_phase(PHASE_ITEMS);
    wait_drained();
    idle_mode = IDLE_SEND;
    add_random_phase(PHASE_ITEMS);
    wait_drained();
    idle_mode = IDLE_RECV;
    add_random_phase(PHASE_ITEMS);
    wait_drained();
    idle_mode = IDLE_BOTH;
    add_random_phase(PHASE_ITEMS);
    wait_drained();

    // Long receiver hold-off while the sender keeps offering
    idle_mode = IDLE_NONE;
    hold_arm  = 1'b1;
    add_random_phase(PHASE_ITEMS);
    wait_drained();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_outcomes.size() != 0) begin
      $display("%0t ERROR results missing: expected %0d more actual 0",
               $time, pending_outcomes.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
